// File: hdl/mms_pkg.sv
// Shared types and constants for the min/max stack.
package mms_pkg;

	localparam logic [1:0] OP_QUERY = 2'd0;
	localparam logic [1:0] OP_PUSH  = 2'd1;
	localparam logic [1:0] OP_POP   = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_POP_EMPTY = 2'd1;
	localparam logic [1:0] ST_PUSH_FULL = 2'd2;

	localparam logic signed [31:0] NEG_ONE = 32'shFFFF_FFFF;
	localparam logic signed [31:0] SMAX    = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SMIN    = 32'sh8000_0000;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [31:0] run_min;
		logic signed [31:0] run_max;
	} entry_t;

	localparam entry_t EMPTY_ENTRY = '{value: NEG_ONE, run_min: SMAX, run_max: SMIN};

endpackage

// File: hdl/min_max_stack_top.sv
// Min/max stack: entry memory, cached top entry, result register.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, opcode, push_value    | word in
//  out     | out_valid, out_stall, popped_value,       | word out
//          | top_value, min_value, max_value,          |
//          | is_empty, status                          |
//
// Query, push and a pop that empties the stack update the result register
// directly; a pop that leaves entries first refills the cached top from the
// entry memory, whose read data is registered. A new word is taken once
// the result of the previous one has been taken or is taken in the same cycle.
// Reset empties the stack at once; memory contents need no clearing.
// A stalled result holds, together with the cached top it reports.
module min_max_stack_top
	import mms_pkg::*;
#(
	parameter int DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] push_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] popped_value,
	output logic signed [31:0] top_value,
	output logic signed [31:0] min_value,
	output logic signed [31:0] max_value,
	output logic               is_empty,
	output logic [1:0]         status
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t mem [DEPTH];
	entry_t rd_q;
	entry_t top_q;
	entry_t new_entry;

	logic [CW-1:0]      count_q;
	logic               pend_q;
	logic               out_valid_q;
	logic signed [31:0] popped_q;
	logic [1:0]         status_q;

	logic          accept;
	logic          push_ok;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;

	assign in_stall = pend_q || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign push_ok  = accept && (opcode == OP_PUSH) && (count_q != CW'(DEPTH));
	assign waddr    = count_q[AW-1:0];
	assign raddr    = AW'(count_q - CW'(2));

	// empty cache holds INT_MAX / INT_MIN, so the first push needs no special case
	always_comb begin
		new_entry.value   = push_value;
		new_entry.run_min = (push_value < top_q.run_min) ? push_value : top_q.run_min;
		new_entry.run_max = (push_value > top_q.run_max) ? push_value : top_q.run_max;
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[waddr] <= new_entry;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			top_q       <= EMPTY_ENTRY;
			popped_q    <= NEG_ONE;
			status_q    <= ST_OK;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pend_q) begin
				// refill the cached top from memory
				top_q       <= rd_q;
				pend_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end
			if (accept) begin
				popped_q <= NEG_ONE;
				status_q <= ST_OK;
				case (opcode)
					OP_PUSH: begin
						out_valid_q <= 1'b1;
						if (count_q == CW'(DEPTH)) begin
							status_q <= ST_PUSH_FULL;
						end else begin
							top_q   <= new_entry;
							count_q <= count_q + CW'(1);
						end
					end
					OP_POP: begin
						if (count_q == '0) begin
							status_q    <= ST_POP_EMPTY;
							out_valid_q <= 1'b1;
						end else begin
							popped_q <= top_q.value;
							count_q  <= count_q - CW'(1);
							if (count_q == CW'(1)) begin
								top_q       <= EMPTY_ENTRY;
								out_valid_q <= 1'b1;
							end else begin
								pend_q      <= 1'b1;
								out_valid_q <= 1'b0;
							end
						end
					end
					default: begin
						out_valid_q <= 1'b1;
					end
				endcase
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign popped_value = popped_q;
	assign top_value    = top_q.value;
	assign min_value    = top_q.run_min;
	assign max_value    = top_q.run_max;
	assign is_empty     = (count_q == '0);
	assign status       = status_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	a_pend_result: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |=> (out_valid_q && !pend_q))
		else $error("refill did not produce a result");

	a_pend_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (in_stall && !out_valid_q))
		else $error("word accepted during refill");

	a_top_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_empty) |-> (min_value <= top_value && max_value >= top_value))
		else $error("top outside running min/max");

	a_empty_cache: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_empty) |-> (top_value == NEG_ONE && min_value == SMAX
			&& max_value == SMIN))
		else $error("empty stack reports stale top");

endmodule

// File: sim/min_max_stack_top_tb.sv
// Testbench for the min/max stack: random push/pop/query words checked against a shadow stack.
`timescale 1ns / 100ps

module min_max_stack_top_tb;
	import mms_pkg::*;

	localparam int STACK_DEPTH = 256;

	// opcode with no meaning; the stack treats it as a query
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct {
		logic [1:0]         opcode;
		logic signed [31:0] value;
	} stack_op_t;

	typedef struct {
		logic signed [31:0] popped;
		logic signed [31:0] top;
		logic signed [31:0] low;
		logic signed [31:0] high;
		logic               empty;
		logic [1:0]         st;
	} stack_view_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         opcode = OP_QUERY;
	logic signed [31:0] push_value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] popped_value;
	logic signed [31:0] top_value;
	logic signed [31:0] min_value;
	logic signed [31:0] max_value;
	logic               is_empty;
	logic [1:0]         status;

	stack_op_t   op_queue[$];
	stack_view_t pending_results[$];

	// shadow copy of the stack contents
	logic signed [31:0] shadow_val[STACK_DEPTH];
	logic signed [31:0] shadow_min[STACK_DEPTH];
	logic signed [31:0] shadow_max[STACK_DEPTH];
	int                 shadow_count = 0;

	int fail_count = 0;
	int result_index = 0;
	int gap_left = 0;
	int hold_left = 0;
	int source_calm = 0;
	int sink_calm = 0;

	min_max_stack_top #(.DEPTH(STACK_DEPTH)) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.push_value   (push_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.popped_value (popped_value),
		.top_value    (top_value),
		.min_value    (min_value),
		.max_value    (max_value),
		.is_empty     (is_empty),
		.status       (status)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Draw a random wait, with occasional stretches of back-to-back words.
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 12);
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return SMIN;
			1: return SMAX;
			2: return NEG_ONE;
			3: return 32'sd0;
			4, 5: return $signed($urandom_range(0, 200)) - 32'sd100;
			default: return $signed($urandom);
		endcase
	endfunction

	function automatic stack_view_t apply_stack_op(logic [1:0] op, logic signed [31:0] v);
		stack_view_t r;
		logic signed [31:0] lo, hi;
		r.popped = NEG_ONE;
		r.st = ST_OK;
		if (op == OP_PUSH) begin
			if (shadow_count >= STACK_DEPTH) begin
				r.st = ST_PUSH_FULL;
			end else begin
				lo = v;
				hi = v;
				if (shadow_count > 0) begin
					if (shadow_min[shadow_count - 1] < v)
						lo = shadow_min[shadow_count - 1];
					if (shadow_max[shadow_count - 1] > v)
						hi = shadow_max[shadow_count - 1];
				end
				shadow_val[shadow_count] = v;
				shadow_min[shadow_count] = lo;
				shadow_max[shadow_count] = hi;
				shadow_count++;
			end
		end else if (op == OP_POP) begin
			if (shadow_count == 0) begin
				r.st = ST_POP_EMPTY;
			end else begin
				shadow_count--;
				r.popped = shadow_val[shadow_count];
			end
		end
		if (shadow_count == 0) begin
			r.top = NEG_ONE;
			r.low = SMAX;
			r.high = SMIN;
			r.empty = 1'b1;
		end else begin
			r.top = shadow_val[shadow_count - 1];
			r.low = shadow_min[shadow_count - 1];
			r.high = shadow_max[shadow_count - 1];
			r.empty = 1'b0;
		end
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("%0t: word %0d %s got %h want %h", $time, result_index, field, got, want);
		fail_count++;
	endtask

	task automatic check_result();
		stack_view_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("unexpected word", popped_value, '0);
			return;
		end
		want = pending_results.pop_front();
		if (popped_value !== want.popped)
			report_mismatch("popped_value", popped_value, want.popped);
		if (top_value !== want.top)
			report_mismatch("top_value", top_value, want.top);
		if (min_value !== want.low)
			report_mismatch("min_value", min_value, want.low);
		if (max_value !== want.high)
			report_mismatch("max_value", max_value, want.high);
		if (is_empty !== want.empty)
			report_mismatch("is_empty", is_empty, want.empty);
		if (status !== want.st)
			report_mismatch("status", status, want.st);
		result_index++;
	endtask

	task automatic add_op(logic [1:0] op, logic signed [31:0] v);
		stack_op_t item;
		item.opcode = op;
		item.value = v;
		op_queue.push_back(item);
	endtask

	// Build the whole word sequence up front, tracking depth to steer the phases.
	task automatic build_stimulus();
		int depth;
		int full_hits;
		logic [1:0] op;
		add_op(OP_QUERY, 32'sd0);
		add_op(OP_POP, 32'sd0);
		add_op(OP_SPARE, 32'sd7);
		add_op(OP_PUSH, 32'sd0);
		add_op(OP_PUSH, SMIN);
		add_op(OP_PUSH, SMAX);
		add_op(OP_PUSH, NEG_ONE);
		add_op(OP_PUSH, 32'sd5);
		add_op(OP_QUERY, 32'sh1234_5678);
		add_op(OP_SPARE, NEG_ONE);
		repeat (5) add_op(OP_POP, 32'sd0);
		add_op(OP_POP, SMAX);
		add_op(OP_PUSH, SMAX);
		add_op(OP_PUSH, SMIN);
		add_op(OP_POP, 32'sd0);
		add_op(OP_POP, 32'sd0);
		add_op(OP_PUSH, 32'sh5555_5555);
		add_op(OP_PUSH, 32'shAAAA_AAAA);
		add_op(OP_POP, 32'sd0);
		add_op(OP_POP, 32'sd0);

		// shallow mix around the empty boundary
		depth = 0;
		repeat (40) begin
			op = 2'($urandom_range(0, 3));
			if (op == OP_PUSH) depth++;
			else if (op == OP_POP && depth > 0) depth--;
			add_op(op, pick_value());
		end

		// fill to full and push past it
		full_hits = 0;
		while (full_hits < 3) begin
			case ($urandom_range(0, 24))
				0: op = OP_POP;
				1: op = OP_QUERY;
				2: op = OP_SPARE;
				default: op = OP_PUSH;
			endcase
			if (op == OP_PUSH) begin
				if (depth == STACK_DEPTH) full_hits++;
				else depth++;
			end else if (op == OP_POP && depth > 0) begin
				depth--;
			end
			add_op(op, pick_value());
		end

		// walk back down from full, mostly pops
		repeat (30) begin
			case ($urandom_range(0, 24))
				0: op = OP_PUSH;
				1: op = OP_QUERY;
				2: op = OP_SPARE;
				default: op = OP_POP;
			endcase
			add_op(op, pick_value());
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic      holding;
		stack_op_t item;
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= OP_QUERY;
			push_value <= '0;
			gap_left = 0;
		end else begin
			holding = in_valid;
			if (in_valid && !in_stall) begin
				pending_results.push_back(apply_stack_op(opcode, push_value));
				holding = 1'b0;
			end
			if (!holding) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (op_queue.size() > 0) begin
					item = op_queue.pop_front();
					opcode <= item.opcode;
					push_value <= item.value;
					in_valid <= 1'b1;
					gap_left = draw_wait(source_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				check_result();
				hold_left = draw_wait(sink_calm);
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		build_stimulus();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (op_queue.size() > 0 || in_valid || pending_results.size() > 0)
			@(posedge clk);
		// catch any stray word after the last expected one
		repeat (20) @(posedge clk);
		if (op_queue.size() > 0 || in_valid || pending_results.size() > 0)
			report_mismatch("missing word", 32'(pending_results.size()), '0);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: sim.f
hdl/mms_pkg.sv
hdl/min_max_stack_top.sv
sim/min_max_stack_top_tb.sv
